FILE: sv/number_to_glyph_rows_defines.svh
`ifndef NUMBER_TO_GLYPH_ROWS_DEFINES_SVH
`define NUMBER_TO_GLYPH_ROWS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NTG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntg assertion failed");

// next-cycle implication, checked out of reset
`define NTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntg assertion failed");

`endif

FILE: sv/ntg_pkg.sv
package ntg_pkg;

    localparam int VALUE_W    = 32;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int COUNT_W    = 8;
    localparam int ROWS_W     = 64;
    localparam int NIBBLE_W   = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * NIBBLE_W;
    localparam int GLYPH_CW   = 4;

    localparam int DD_STAGES    = 4;
    localparam int DD_PER_STAGE = VALUE_W / DD_STAGES;

    localparam int DIGIT_W = 16;
    localparam logic [COORD_W-1:0] DIGIT_STEP = COORD_W'(DIGIT_W);

    localparam logic [GLYPH_CW-1:0] MAX_GLYPHS = GLYPH_CW'(BCD_DIGITS);
    localparam logic [VALUE_W-1:0]  SINGLE_MAX = VALUE_W'(15);

    typedef enum logic [1:0] {
        REQ_SINGLE = 2'd0,
        REQ_HEX32  = 2'd1,
        REQ_HEX16  = 2'd2,
        REQ_DEC    = 2'd3
    } t_req_kind;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [VALUE_W-1:0]        value;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic [COUNT_W-1:0]        digit_count;
        logic [COLOR_W-1:0]        fg_in;
        logic [COLOR_W-1:0]        bg_in;
    } t_req;

    typedef struct packed {
        t_req               req;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_dd;

    localparam logic [ROWS_W-1:0] FONT [16] = '{
        64'h3C42424242423C00,
        64'h1838181818183C00,
        64'h3C42040830407E00,
        64'h7C02023C02027C00,
        64'h0C1C2C4C7E0C0C00,
        64'h7E40407C02027C00,
        64'h3C40407C42423C00,
        64'h7E02040810202000,
        64'h3C42423C42423C00,
        64'h3C42423E02023C00,
        64'h182442427E424200,
        64'h7C42427C42427C00,
        64'h3C42404040423C00,
        64'h7C42424242427C00,
        64'h7E40407C40407E00,
        64'h7E40407C40404000
    };

    // double dabble, a slice of the binary-to-bcd shifts
    function automatic t_dd dd_run(input t_dd d);
        t_dd r;
        r = d;
        for (int s = 0; s < DD_PER_STAGE; s++) begin
            for (int k = 0; k < BCD_DIGITS; k++) begin
                if (r.bcd[NIBBLE_W*k +: NIBBLE_W] >= 4'd5) begin
                    r.bcd[NIBBLE_W*k +: NIBBLE_W] = r.bcd[NIBBLE_W*k +: NIBBLE_W] + 4'd3;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
            r.bin = {r.bin[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: sv/ntg_req_if.sv
interface ntg_req_if import ntg_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [VALUE_W-1:0]        value;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic [COUNT_W-1:0]        digit_count;
    logic [COLOR_W-1:0]        fg_in;
    logic [COLOR_W-1:0]        bg_in;

    modport source (
        output valid, req_type, value, x_pos, y_pos, digit_count, fg_in, bg_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, value, x_pos, y_pos, digit_count, fg_in, bg_in,
        output ready
    );
endinterface

FILE: sv/ntg_glyph_if.sv
interface ntg_glyph_if import ntg_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] win_x;
    logic signed [COORD_W-1:0] win_y;
    logic [ROWS_W-1:0]         glyph_rows;
    logic [COLOR_W-1:0]        fg_out;
    logic [COLOR_W-1:0]        bg_out;
    logic                      last_glyph;

    modport source (
        output valid, win_x, win_y, glyph_rows, fg_out, bg_out, last_glyph,
        input  ready
    );

    modport sink (
        input  valid, win_x, win_y, glyph_rows, fg_out, bg_out, last_glyph,
        output ready
    );
endinterface

FILE: sv/ntg_dabble_stage.sv
module ntg_dabble_stage import ntg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dd  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_dd  o_data
);

    logic r_valid;
    t_dd  r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= dd_run(i_data);
        end
    end

endmodule

FILE: sv/number_to_glyph_rows.sv
// path: request beat, double-dabble stages, align register, glyph serializer, output
// register; throughput: one glyph beat per cycle while o_glyph.ready is high; a request
// makes 1 (single), 8 (hex32), 4 (hex16) or n (decimal) glyphs, zero-digit decimal none
// the serializer feeding the output register sets the request rate
// reset: synchronous active low, clears pipeline valid bits only
module number_to_glyph_rows import ntg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ntg_req_if.sink          i_req,
    ntg_glyph_if.source      o_glyph
);

`include "number_to_glyph_rows_defines.svh"

    // binary to bcd pipeline
    t_dd  dd_data  [DD_STAGES+1];
    logic dd_valid [DD_STAGES+1];
    logic dd_ready [DD_STAGES+1];

    assign dd_data[0].req.req_type    = i_req.req_type;
    assign dd_data[0].req.value       = i_req.value;
    assign dd_data[0].req.x_pos       = i_req.x_pos;
    assign dd_data[0].req.y_pos       = i_req.y_pos;
    assign dd_data[0].req.digit_count = i_req.digit_count;
    assign dd_data[0].req.fg_in       = i_req.fg_in;
    assign dd_data[0].req.bg_in       = i_req.bg_in;
    assign dd_data[0].bcd             = '0;
    assign dd_data[0].bin             = i_req.value;
    assign dd_valid[0]                = i_req.valid;
    assign i_req.ready                = dd_ready[0];

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        ntg_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dd_valid[g]),
            .o_ready (dd_ready[g]),
            .i_data  (dd_data[g]),
            .o_valid (dd_valid[g+1]),
            .i_ready (dd_ready[g+1]),
            .o_data  (dd_data[g+1])
        );
    end

    // align stage: left-justify the digits and work out the glyph count
    t_dd                       dd_out;
    logic [GLYPH_CW-1:0]       dec_n;
    logic [GLYPH_CW-1:0]       dec_sh;
    logic [BCD_W-1:0]          n_al_digits;
    logic [GLYPH_CW-1:0]       n_al_cnt;
    logic                      al_ready;
    logic                      r_al_valid;
    logic [BCD_W-1:0]          r_al_digits;
    logic [GLYPH_CW-1:0]       r_al_cnt;
    logic signed [COORD_W-1:0] r_al_x;
    logic signed [COORD_W-1:0] r_al_y;
    logic [COLOR_W-1:0]        r_al_fg;
    logic [COLOR_W-1:0]        r_al_bg;

    assign dd_out = dd_data[DD_STAGES];
    assign dec_n  = (dd_out.req.digit_count > COUNT_W'(BCD_DIGITS)) ? MAX_GLYPHS
                  : dd_out.req.digit_count[GLYPH_CW-1:0];
    assign dec_sh = MAX_GLYPHS - dec_n;

    always_comb begin
        unique case (t_req_kind'(dd_out.req.req_type))
            REQ_SINGLE: begin
                n_al_digits = {((dd_out.req.value > SINGLE_MAX) ? 4'd0
                                : dd_out.req.value[NIBBLE_W-1:0]),
                               (BCD_W-NIBBLE_W)'(0)};
                n_al_cnt    = GLYPH_CW'(1);
            end
            REQ_HEX32: begin
                n_al_digits = {dd_out.req.value, (BCD_W-VALUE_W)'(0)};
                n_al_cnt    = GLYPH_CW'(8);
            end
            REQ_HEX16: begin
                n_al_digits = {dd_out.req.value[15:0], (BCD_W-16)'(0)};
                n_al_cnt    = GLYPH_CW'(4);
            end
            REQ_DEC: begin
                n_al_digits = dd_out.bcd << {dec_sh, 2'b00};
                n_al_cnt    = dec_n;
            end
        endcase
    end

    // glyph serializer and output register
    logic                      out_free;
    logic                      ser_ready;
    logic                      ser_load;
    logic                      ser_emit;
    logic                      ser_last;
    logic                      r_ser_valid;
    logic [BCD_W-1:0]          r_digits;
    logic [GLYPH_CW-1:0]       r_left;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [COLOR_W-1:0]        r_fg;
    logic [COLOR_W-1:0]        r_bg;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_win_x;
    logic signed [COORD_W-1:0] r_win_y;
    logic [ROWS_W-1:0]         r_rows;
    logic [COLOR_W-1:0]        r_fg_out;
    logic [COLOR_W-1:0]        r_bg_out;
    logic                      r_out_last;

    assign out_free  = !r_out_valid || o_glyph.ready;
    assign ser_last  = (r_left == '0);
    assign ser_emit  = r_ser_valid && out_free;
    assign ser_ready = !r_ser_valid || (out_free && ser_last);
    assign ser_load  = r_al_valid && ser_ready;
    assign al_ready  = !r_al_valid || ser_ready;
    assign dd_ready[DD_STAGES] = al_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_al_valid <= 1'b0;
        end else if (al_ready) begin
            r_al_valid <= dd_valid[DD_STAGES] && (n_al_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (al_ready && dd_valid[DD_STAGES]) begin
            r_al_digits <= n_al_digits;
            r_al_cnt    <= n_al_cnt;
            r_al_x      <= dd_out.req.x_pos;
            r_al_y      <= dd_out.req.y_pos;
            r_al_fg     <= dd_out.req.fg_in;
            r_al_bg     <= dd_out.req.bg_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
        end else if (ser_emit && ser_last) begin
            r_ser_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_digits <= r_al_digits;
            r_left   <= r_al_cnt - GLYPH_CW'(1);
            r_x      <= r_al_x;
            r_y      <= r_al_y;
            r_fg     <= r_al_fg;
            r_bg     <= r_al_bg;
        end else if (ser_emit) begin
            r_digits <= r_digits << NIBBLE_W;
            r_left   <= r_left - GLYPH_CW'(1);
            r_x      <= r_x + DIGIT_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ser_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_glyph.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_emit) begin
            r_win_x    <= r_x;
            r_win_y    <= r_y;
            r_rows     <= FONT[r_digits[BCD_W-1 -: NIBBLE_W]];
            r_fg_out   <= r_fg;
            r_bg_out   <= r_bg;
            r_out_last <= ser_last;
        end
    end

    assign o_glyph.valid      = r_out_valid;
    assign o_glyph.win_x      = r_win_x;
    assign o_glyph.win_y      = r_win_y;
    assign o_glyph.glyph_rows = r_rows;
    assign o_glyph.fg_out     = r_fg_out;
    assign o_glyph.bg_out     = r_bg_out;
    assign o_glyph.last_glyph = r_out_last;

    `NTG_ASSERT_NOW(a_al_cnt_range, i_clk, i_rst_n, r_al_valid,
        (r_al_cnt != '0) && (r_al_cnt <= MAX_GLYPHS))
    `NTG_ASSERT_NOW(a_ser_left_range, i_clk, i_rst_n, r_ser_valid, r_left < MAX_GLYPHS)
    `NTG_ASSERT_NEXT(a_ser_keeps_req, i_clk, i_rst_n, ser_emit && !ser_last, r_ser_valid)
    `NTG_ASSERT_NOW(a_mid_glyph_has_rest, i_clk, i_rst_n, r_out_valid && !r_out_last,
        r_ser_valid)

endmodule

FILE: sim/number_to_glyph_rows_test.sv
module number_to_glyph_rows_test import ntg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 80;
    localparam int REPORT_MAX   = 10;

    localparam logic [ROWS_W-1:0] GLYPH_FONT [16] = '{
        64'h3C42424242423C00, 64'h1838181818183C00, 64'h3C42040830407E00,
        64'h7C02023C02027C00, 64'h0C1C2C4C7E0C0C00, 64'h7E40407C02027C00,
        64'h3C40407C42423C00, 64'h7E02040810202000, 64'h3C42423C42423C00,
        64'h3C42423E02023C00, 64'h182442427E424200, 64'h7C42427C42427C00,
        64'h3C42404040423C00, 64'h7C42424242427C00, 64'h7E40407C40407E00,
        64'h7E40407C40404000
    };

    typedef struct packed {
        logic [COORD_W-1:0] win_x;
        logic [COORD_W-1:0] win_y;
        logic [ROWS_W-1:0]  rows;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               last;
    } t_glyph_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ntg_req_if   req_bus ();
    ntg_glyph_if glyph_bus ();

    number_to_glyph_rows uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_glyph (glyph_bus)
    );

    t_glyph_beat pending_glyphs[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          gaps_on     = 1'b0;
    int          burst_left  = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void log_mismatch(string msg);
        error_count++;
        if (error_count <= REPORT_MAX) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    function automatic void check_field(string name, logic [ROWS_W-1:0] want,
                                        logic [ROWS_W-1:0] got);
        if (want !== got) begin
            log_mismatch($sformatf("%s expected %h actual %h", name, want, got));
        end
    endfunction

    // splits the value into glyph indexes, most significant first
    function automatic void render_glyphs(t_req r);
        logic [NIBBLE_W-1:0] digits [BCD_DIGITS];
        int                  count;
        longint unsigned     rest;
        longint unsigned     scale;
        t_glyph_beat         beat;

        count = 0;
        case (t_req_kind'(r.req_type))
            REQ_SINGLE: begin
                count = 1;
                digits[0] = (r.value > 32'd15) ? 4'd0 : r.value[3:0];
            end
            REQ_HEX32: begin
                count = 8;
                for (int i = 0; i < count; i++) digits[i] = r.value[4*(7-i) +: 4];
            end
            REQ_HEX16: begin
                count = 4;
                for (int i = 0; i < count; i++) digits[i] = r.value[4*(3-i) +: 4];
            end
            default: begin
                count = (r.digit_count > 8'd10) ? 10 : int'(r.digit_count);
                scale = 1;
                for (int i = 0; i < count; i++) scale = scale * 10;
                rest = longint'(r.value) % scale;
                for (int i = 0; i < count; i++) begin
                    scale = scale / 10;
                    digits[i] = NIBBLE_W'(rest / scale);
                    rest = rest % scale;
                end
            end
        endcase
        for (int i = 0; i < count; i++) begin
            beat.win_x = r.x_pos + COORD_W'(i * DIGIT_W);
            beat.win_y = r.y_pos;
            beat.rows  = GLYPH_FONT[digits[i]];
            beat.fg    = r.fg_in;
            beat.bg    = r.bg_in;
            beat.last  = (i == count - 1);
            pending_glyphs.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_req        seen;
        t_glyph_beat got;
        t_glyph_beat want;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                seen.req_type    = req_bus.req_type;
                seen.value       = req_bus.value;
                seen.x_pos       = req_bus.x_pos;
                seen.y_pos       = req_bus.y_pos;
                seen.digit_count = req_bus.digit_count;
                seen.fg_in       = req_bus.fg_in;
                seen.bg_in       = req_bus.bg_in;
                render_glyphs(seen);
            end
            if (glyph_bus.valid && glyph_bus.ready) begin
                got.win_x = glyph_bus.win_x;
                got.win_y = glyph_bus.win_y;
                got.rows  = glyph_bus.glyph_rows;
                got.fg    = glyph_bus.fg_out;
                got.bg    = glyph_bus.bg_out;
                got.last  = glyph_bus.last_glyph;
                if (pending_glyphs.size() == 0) begin
                    log_mismatch($sformatf("unexpected glyph beat x %h rows %h",
                                           got.win_x, got.rows));
                end else begin
                    want = pending_glyphs.pop_front();
                    check_field("win_x", want.win_x, got.win_x);
                    check_field("win_y", want.win_y, got.win_y);
                    check_field("glyph_rows", want.rows, got.rows);
                    check_field("fg_out", want.fg, got.fg);
                    check_field("bg_out", want.bg, got.bg);
                    check_field("last_glyph", want.last, got.last);
                end
            end
        end
    end

    // receiver stalls follow a rotating pattern, redrawn whenever rx_hold runs out
    initial begin
        logic [15:0] rx_pattern;
        int          rx_hold;
        rx_pattern = '1;
        rx_hold = 0;
        glyph_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_pattern = '1;
                    1: rx_pattern = 16'($urandom);
                    2: rx_pattern = ~(16'h1 << $urandom_range(0, 15));
                    default: rx_pattern = 16'($urandom) | 16'($urandom);
                endcase
                rx_hold = 50;
            end
            rx_hold--;
            glyph_bus.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("number_to_glyph_rows regression: fail");
        $finish;
    end

    function automatic t_req make_request(t_req_kind kind, logic [VALUE_W-1:0] value,
                                          logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                          logic [COUNT_W-1:0] count,
                                          logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
        t_req r;
        r.req_type    = kind;
        r.value       = value;
        r.x_pos       = x;
        r.y_pos       = y;
        r.digit_count = count;
        r.fg_in       = fg;
        r.bg_in       = bg;
        return r;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                @(negedge i_clk);
                req_bus.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= r.req_type;
        req_bus.value       <= r.value;
        req_bus.x_pos       <= r.x_pos;
        req_bus.y_pos       <= r.y_pos;
        req_bus.digit_count <= r.digit_count;
        req_bus.fg_in       <= r.fg_in;
        req_bus.bg_in       <= r.bg_in;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    task automatic test_single_digit();
        send_request(make_request(REQ_SINGLE, 32'd0, 16'd0, 16'd0, 8'd0, 16'h0000, 16'hFFFF));
        send_request(make_request(REQ_SINGLE, 32'd9, 16'd5, 16'd7, 8'd3, 16'hF800, 16'h07E0));
        send_request(make_request(REQ_SINGLE, 32'd15, 16'd100, 16'd20, 8'd0, 16'h001F, 16'h0));
        // out of range draws zero
        send_request(make_request(REQ_SINGLE, 32'd16, 16'd0, 16'd0, 8'd0, 16'h1234, 16'h4321));
        send_request(make_request(REQ_SINGLE, 32'hFFFF_FFFF, 16'd1, 16'd1, 8'hFF,
                                  16'hAAAA, 16'h5555));
        send_request(make_request(REQ_SINGLE, 32'h1000_0005, 16'd2, 16'd2, 8'd1,
                                  16'h5555, 16'hAAAA));
    endtask

    task automatic test_hex_values();
        send_request(make_request(REQ_HEX32, 32'h89AB_CDEF, 16'd0, 16'd8, 8'd0,
                                  16'hFFFF, 16'h0000));
        send_request(make_request(REQ_HEX32, 32'h0123_4567, 16'd16, 16'd8, 8'd7,
                                  16'h0F0F, 16'hF0F0));
        send_request(make_request(REQ_HEX32, 32'hFFFF_FFFF, 16'd32, 16'd8, 8'd200,
                                  16'h0000, 16'hFFFF));
        send_request(make_request(REQ_HEX16, 32'hDEAD_BEEF, 16'd48, 16'd16, 8'd0,
                                  16'h1111, 16'h2222));
        send_request(make_request(REQ_HEX16, 32'h0000_0000, 16'd64, 16'd16, 8'd10,
                                  16'h3333, 16'h4444));
    endtask

    task automatic test_decimal_counts();
        // zero count draws nothing
        send_request(make_request(REQ_DEC, 32'd5, 16'd0, 16'd0, 8'd0, 16'h1, 16'h2));
        send_request(make_request(REQ_DEC, 32'd987654321, 16'd0, 16'd0, 8'd1, 16'h3, 16'h4));
        send_request(make_request(REQ_DEC, 32'd123456, 16'd0, 16'd0, 8'd3, 16'h5, 16'h6));
        send_request(make_request(REQ_DEC, 32'hFFFF_FFFF, 16'd0, 16'd0, 8'd10, 16'h7, 16'h8));
        send_request(make_request(REQ_DEC, 32'd1234567890, 16'd0, 16'd0, 8'd11, 16'h9, 16'hA));
        send_request(make_request(REQ_DEC, 32'd42, 16'd0, 16'd0, 8'd255, 16'hB, 16'hC));
        send_request(make_request(REQ_DEC, 32'd0, 16'd0, 16'd0, 8'd10, 16'hD, 16'hE));
    endtask

    task automatic test_position_wrap();
        send_request(make_request(REQ_HEX32, 32'h1357_9BDF, 16'h7FFF, 16'h8000, 8'd0,
                                  16'hFFFF, 16'h0000));
        send_request(make_request(REQ_SINGLE, 32'd7, 16'h8000, 16'h7FFF, 8'd0,
                                  16'h0000, 16'hFFFF));
        // digit count has no effect on hex requests
        send_request(make_request(REQ_HEX16, 32'h0000_A5C3, 16'h7FF8, 16'hFFFF, 8'd0,
                                  16'h8000, 16'h0001));
        send_request(make_request(REQ_DEC, 32'd4000000000, 16'hFFFF, 16'd0, 8'd9,
                                  16'h0001, 16'h8000));
    endtask

    function automatic t_req random_request();
        t_req r;
        r.req_type = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: r.value = $urandom_range(0, 31);
            1: r.value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            2: r.value = $urandom >> $urandom_range(0, 31);
            default: r.value = $urandom;
        endcase
        r.x_pos = ($urandom_range(0, 3) == 0) ? 16'h7FFF - 16'($urandom_range(0, 200))
                                              : 16'($urandom);
        r.y_pos = 16'($urandom);
        if (t_req_kind'(r.req_type) == REQ_DEC && $urandom_range(0, 3) != 0) begin
            r.digit_count = 8'($urandom_range(1, 10));
        end else begin
            r.digit_count = 8'($urandom);
        end
        r.fg_in = 16'($urandom);
        r.bg_in = 16'($urandom);
        return r;
    endfunction

    task automatic test_random_requests();
        int   drawn;
        t_req r;
        drawn = 0;
        while (drawn < RANDOM_ITEMS) begin
            // a stretch in the middle goes back to back
            gaps_on = (drawn < 30 || drawn >= 55);
            r = random_request();
            send_request(r);
            if (!(t_req_kind'(r.req_type) == REQ_DEC && r.digit_count == 8'd0)) drawn++;
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_SINGLE;
        req_bus.value       = '0;
        req_bus.x_pos       = '0;
        req_bus.y_pos       = '0;
        req_bus.digit_count = '0;
        req_bus.fg_in       = '0;
        req_bus.bg_in       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_digit();
        gaps_on = 1'b1;
        test_hex_values();
        gaps_on = 1'b0;
        test_decimal_counts();
        gaps_on = 1'b1;
        test_position_wrap();
        test_random_requests();

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending_glyphs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_glyphs.size() != 0) begin
            log_mismatch($sformatf("%0d glyph beats never arrived", pending_glyphs.size()));
        end
        if (error_count == 0) begin
            $display("number_to_glyph_rows regression: pass");
        end else begin
            $display("number_to_glyph_rows regression: fail");
        end
        $finish;
    end

endmodule
